// ----- sv/fixed_point_sigmoid_pwl_defines.svh -----
// Assertion macros for the sigmoid block.
`ifndef FIXED_POINT_SIGMOID_PWL_DEFINES_SVH
`define FIXED_POINT_SIGMOID_PWL_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/fxsig_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fxsig_pkg;

  localparam int Segments = 16;
  localparam int SegW     = $clog2(Segments);
  localparam int MagW     = 17;

  localparam logic [MagW-1:0] BandTop [Segments] = '{
    17'd971,   17'd1699,  17'd2347,  17'd2974,  17'd3614,  17'd4291,  17'd5026,  17'd5861,
    17'd6831,  17'd7864,  17'd8987,  17'd10375, 17'd11594, 17'd13168, 17'd14730, 17'd32768
  };

  localparam logic [15:0] SegSlope [Segments] = '{
    16'd32316, 16'd29471, 16'd25891, 16'd22068, 16'd18225, 16'd29057, 16'd22206, 16'd16113,
    16'd10881, 16'd27353, 16'd16611, 16'd9242,  16'd4618,  16'd20670, 16'd8610,  16'd693
  };

  localparam logic [14:0] BiasPos [Segments] = '{
    15'd16384, 15'd16721, 15'd17464, 15'd18559, 15'd19954, 15'd21585, 15'd23380, 15'd25249,
    15'd27121, 15'd28807, 15'd30096, 15'd31107, 15'd31839, 15'd32199, 15'd32502, 15'd32724
  };

  localparam logic [14:0] BiasNeg [Segments] = '{
    15'd16384, 15'd16047, 15'd15304, 15'd14209, 15'd12814, 15'd11183, 15'd9388,  15'd7519,
    15'd5647,  15'd3961,  15'd2672,  15'd1661,  15'd929,   15'd569,   15'd266,   15'd44
  };

  localparam logic [4:0] ShiftA = 5'd13;
  localparam logic [4:0] ShiftB = 5'd14;
  localparam logic [4:0] ShiftC = 5'd16;
  localparam logic [4:0] ShiftD = 5'd19;

  // One classified sample on its way from front to back.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [SegW-1:0]    seg;
  } fxsig_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fxsig_qstat_t;

  function automatic logic [4:0] seg_shift(input logic [SegW-1:0] seg);
    logic [4:0] sh;
    if (seg < SegW'(5)) begin
      sh = ShiftA;
    end else if (seg < SegW'(9)) begin
      sh = ShiftB;
    end else if (seg < SegW'(13)) begin
      sh = ShiftC;
    end else begin
      sh = ShiftD;
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fxsig_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fxsig_front import fxsig_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               sample_valid_i,
  output logic                    sample_ready_o,
  input  wire fxsig_qstat_t       q_stat_i,
  output logic                    push_o,
  output fxsig_item_t             item_o,
  output logic                    busy_o
);

  logic            valid_q, valid_d;
  fxsig_item_t     item_q;
  logic [MagW-1:0] mag;
  logic [SegW-1:0] seg;
  logic            take;

  assign mag = sample_i[15] ? (MagW'(0) - {sample_i[15], sample_i})
                            : {1'b0, sample_i};

  // Pick the first band whose top is at or above the magnitude.
  always_comb begin
    seg = SegW'(Segments - 1);
    for (int i = Segments - 1; i >= 0; i--) begin
      if (mag <= BandTop[i]) begin
        seg = SegW'(i);
      end
    end
  end

  assign push_o         = valid_q && !q_stat_i.full;
  assign sample_ready_o = !valid_q || !q_stat_i.full;
  assign take           = sample_valid_i && sample_ready_o;
  assign item_o         = item_q;
  assign busy_o         = valid_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.sample <= sample_i;
      item_q.seg    <= seg;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fxsig_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fxsig_queue import fxsig_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire fxsig_item_t  item_i,
  input  wire logic         pop_i,
  output fxsig_item_t       head_o,
  output fxsig_qstat_t      stat_o
);

  fxsig_item_t entry_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_o       = entry_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = pop_i  ? !rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fxsig_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fxsig_back import fxsig_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fxsig_item_t  head_i,
  input  wire fxsig_qstat_t q_stat_i,
  output logic              pop_o,
  output logic [14:0]       activation_o,
  output logic              activation_valid_o,
  input  wire logic         activation_ready_i
);

  // Stage 1: product register.
  logic               s1_valid_q, s1_valid_d;
  logic signed [31:0] prod_q;
  logic [SegW-1:0]    seg_q;
  logic               neg_q;
  // Stage 2: output register.
  logic               s2_valid_q, s2_valid_d;
  logic [14:0]        act_q;

  logic               s1_load, s2_load;
  logic signed [31:0] slope_ext, sample_ext, prod_d;
  logic signed [31:0] shifted, bias_ext, sum;
  logic [14:0]        act_d;

  assign s2_load = !s2_valid_q || activation_ready_i;
  assign s1_load = !s1_valid_q || s2_load;
  assign pop_o   = !q_stat_i.empty && s1_load;

  assign slope_ext  = $signed({16'd0, SegSlope[head_i.seg]});
  assign sample_ext = 32'(head_i.sample);
  assign prod_d     = slope_ext * sample_ext;

  // Arithmetic shift floors toward minus infinity.
  assign shifted  = prod_q >>> seg_shift(seg_q);
  assign bias_ext = $signed({17'd0, (neg_q ? BiasNeg[seg_q] : BiasPos[seg_q])});
  assign sum      = shifted + bias_ext;

  always_comb begin
    if (sum < 0) begin
      act_d = 15'd0;
    end else if (sum > 32'sd32767) begin
      act_d = 15'h7fff;
    end else begin
      act_d = sum[14:0];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = pop_o;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= prod_d;
      seg_q  <= head_i.seg;
      neg_q  <= head_i.sample[15];
    end
    if (s2_load && s1_valid_q) begin
      act_q <= act_d;
    end
  end

  assign activation_o       = act_q;
  assign activation_valid_o = s2_valid_q;

endmodule

`default_nettype wire

// ----- sv/fixed_point_sigmoid_pwl.sv -----
// Piecewise-linear sigmoid over 16 segments.
// Input channel: sample_i (signed 16-bit fixed point) with sample_valid_i /
// sample_ready_o. A transaction completes at a rising edge with both high.
// Output channel: activation_o (Q15, 16384 is one half) with
// activation_valid_o / activation_ready_i, one result per input transaction,
// in order.
// Throughput: one transaction per cycle on each side, sustained while activation_ready_i is high.
// Path: an input passes through the front register (magnitude and segment
// pick), the two-entry queue and the multiply register, then the output
// register, where activation_valid_o rises.
// A receiver stall backs up the output and multiply registers, then the
// queue, then the front; sample_ready_o drops only once the front register
// holds an item the full queue cannot take. Nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties every stage; the block keeps no
// other state and is ready for input in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_sigmoid_pwl_defines.svh"

module fixed_point_sigmoid_pwl import fxsig_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               sample_valid_i,
  output logic                    sample_ready_o,
  output logic [14:0]             activation_o,
  output logic                    activation_valid_o,
  input  wire logic               activation_ready_i
);

  fxsig_qstat_t q_stat;
  fxsig_item_t  push_item;
  fxsig_item_t  head_item;
  logic         q_push;
  logic         q_pop;
  logic         front_busy;

  fxsig_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .q_stat_i       (q_stat),
    .push_o         (q_push),
    .item_o         (push_item),
    .busy_o         (front_busy)
  );

  fxsig_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  fxsig_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head_item),
    .q_stat_i           (q_stat),
    .pop_o              (q_pop),
    .activation_o       (activation_o),
    .activation_valid_o (activation_valid_o),
    .activation_ready_i (activation_ready_i)
  );

  `ASSERT_IMPL(a_push_has_room, q_push, !q_stat.full)
  `ASSERT_IMPL(a_pop_has_data, q_pop, !q_stat.empty)
  `ASSERT_NEXT(a_accept_fills_front, sample_valid_i && sample_ready_o, front_busy)

endmodule

`default_nettype wire
